### rtl/core/drive_ramp_and_steering_controller_core_assert.svh
// assertion macros used by the drive controller checker
`ifndef DRIVE_RAMP_AND_STEERING_CONTROLLER_CORE_ASSERT_SVH
`define DRIVE_RAMP_AND_STEERING_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define DRSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drsc assertion failed");

// next-cycle implication, off during reset
`define DRSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drsc assertion failed");

// holds in the cycle after reset is seen
`define DRSC_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("drsc reset assertion failed");

`endif

### rtl/core/drsc_pkg.sv
// types, codes and constants of the drive ramp and steering controller
`default_nettype none
package drsc_pkg;

  localparam int PWM_BITS_DEF = 10;
  localparam int TURN_DIV     = 400;
  localparam int FAC_W        = 9;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  localparam logic [7:0]  RAMP_STEP_RST      = 8'd10;
  localparam logic [9:0]  PWM_OFFSET_RST     = 10'd513;
  localparam logic [11:0] STEER_CENTER_RST   = 12'd1500;
  localparam logic [7:0]  STEER_DEADZONE_RST = 8'd25;
  localparam logic [3:0]  STEER_GAIN_RST     = 4'd3;
  localparam logic [7:0]  STOP_TIMEOUT_RST   = 8'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_STEP      = 3'd0,
    CFG_PWM_OFFSET     = 3'd1,
    CFG_STEER_CENTER   = 3'd2,
    CFG_STEER_DEADZONE = 3'd3,
    CFG_STEER_GAIN     = 3'd4,
    CFG_STOP_TIMEOUT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_SPEED = 2'd0,
    FUNC_DIR   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_POT   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    BRIDGE_COAST = 2'd0,
    BRIDGE_FWD   = 2'd1,
    BRIDGE_REV   = 2'd2
  } bridge_t;

  typedef enum logic [1:0] {
    STEER_NONE    = 2'd0,
    STEER_BACK    = 2'd1,
    STEER_FWD     = 2'd2,
    STEER_SETTLED = 2'd3
  } steer_t;

  typedef struct packed {
    logic    duty_valid;
    logic    bridge_write;
    bridge_t bridge_mode;
    steer_t  steer_action;
  } flags_t;

  typedef struct packed {
    logic left;
    logic right;
  } scale_sel_t;

endpackage
`default_nettype wire

### rtl/core/drsc_if.sv
// handshake interfaces for command, result and configuration words
`default_nettype none
interface drsc_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [8:0] speed_cmd;
  logic signed [7:0] direction_cmd;
  logic [11:0]       pot_sample;

  modport source(output valid, func, speed_cmd, direction_cmd, pot_sample, input ready);
  modport sink(input valid, func, speed_cmd, direction_cmd, pot_sample, output ready);
endinterface

interface drsc_res_if import drsc_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                duty_valid;
  logic [PWM_BITS-1:0] left_duty;
  logic [PWM_BITS-1:0] right_duty;
  logic                bridge_write;
  logic [1:0]          bridge_mode;
  logic [1:0]          steer_action;

  modport source(output valid, duty_valid, left_duty, right_duty, bridge_write,
                 bridge_mode, steer_action, input ready);
  modport sink(input valid, duty_valid, left_duty, right_duty, bridge_write,
               bridge_mode, steer_action, output ready);
endinterface

interface drsc_cfg_if import drsc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/drsc_duty.sv
// turn scaling of the motor duties: multiply by the factor, divide by the turn divisor
`default_nettype none
module drsc_duty import drsc_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [PWM_BITS-1:0] base,
  input  logic [FAC_W-1:0]    fac,
  input  scale_sel_t          sel,
  output logic [PWM_BITS-1:0] left_duty,
  output logic [PWM_BITS-1:0] right_duty
);

  localparam int PROD_W  = PWM_BITS + FAC_W;
  // ceiling reciprocal, exact for every product below 2**PROD_W
  localparam int SHIFT   = PROD_W + $clog2(TURN_DIV);
  localparam int RECIP_W = SHIFT - $clog2(TURN_DIV) + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) / TURN_DIV) + 64'd1);
  localparam int FULL_W  = PROD_W + RECIP_W;

  logic [PWM_BITS-1:0] base_a, base_b;
  logic [FAC_W-1:0]    fac_a;
  scale_sel_t          sel_a, sel_b;
  logic [PROD_W-1:0]   prod_b;
  logic [FULL_W-1:0]   full;
  logic [PWM_BITS-1:0] scaled;

  always_ff @(posedge clk) begin
    if (en) begin
      base_a <= base;
      fac_a  <= fac;
      sel_a  <= sel;
      prod_b <= PROD_W'(base_a) * PROD_W'(fac_a);
      base_b <= base_a;
      sel_b  <= sel_a;
      left_duty  <= sel_b.left ? scaled : base_b;
      right_duty <= sel_b.right ? scaled : base_b;
    end
  end

  assign full   = FULL_W'(prod_b) * FULL_W'(RECIP);
  assign scaled = PWM_BITS'(full >> SHIFT);

endmodule
`default_nettype wire

### rtl/core/drive_ramp_and_steering_controller_core.sv
// an accepted command word leaves as a result word from the output register at the end of the pipeline
// throughput: one word per cycle; ready drops only while the output register
// holds a word that is not taken, the three stages advance together
// the duty path is base*factor then a reciprocal multiply for the turn divisor
// reset (synchronous): ramp, steering and watchdog state to zero,
// registers to their defaults, pipeline emptied; no clearing pass
`default_nettype none
module drive_ramp_and_steering_controller_core import drsc_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  drsc_cmd_if.sink  cmd,
  drsc_res_if.source res,
  drsc_cfg_if.sink  cfg
);

  localparam int SUM_W = (PWM_BITS > 11) ? PWM_BITS + 1 : 12;

  // configuration
  logic [7:0]  ramp_step;
  logic [9:0]  pwm_offset;
  logic [11:0] steer_center;
  logic [7:0]  steer_deadzone;
  logic [3:0]  steer_gain;
  logic [7:0]  stop_timeout;

  // controller state
  logic signed [10:0] target_pwm, target_pwm_next;
  logic signed [10:0] ramp_pwm, ramp_pwm_next;
  logic               ramping, ramping_next;
  logic signed [7:0]  steer_dir, steer_dir_next;
  logic               steer_active, steer_active_next;
  logic [7:0]         idle_ticks, idle_ticks_next;

  logic adv, accept;
  logic do_step, fire;
  logic [7:0] idle_inc;
  steer_t act;

  logic signed [11:0] diff;
  logic [10:0]        diff_mag;
  logic signed [10:0] ramp_st;
  logic               ramping_st;

  logic signed [12:0] gain_term;
  logic signed [13:0] err;
  logic [12:0]        err_mag;

  logic [9:0]          ramp_mag;
  logic [SUM_W-1:0]    sum;
  logic [PWM_BITS-1:0] base_in;
  logic [7:0]          dir_mag;
  logic [FAC_W-1:0]    fac_in;
  scale_sel_t          sel_in;
  flags_t              flags_in, flags1, flags2, flags3;
  logic                v1, v2, v3;

  assign adv       = !v3 || res.ready;
  assign accept    = cmd.valid && adv;
  assign cmd.ready = adv;
  assign cfg.ready = 1'b1;

  // steering error against the commanded position
  assign gain_term = 13'(signed'({1'b0, steer_gain})) * 13'(steer_dir);
  assign err = 14'(signed'({1'b0, cmd.pot_sample})) - 14'(signed'({1'b0, steer_center}))
             - 14'(gain_term);
  assign err_mag = err < 0 ? 13'(-err) : 13'(err);

  assign idle_inc = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;
  assign fire     = idle_inc >= stop_timeout;

  always_comb begin
    target_pwm_next   = target_pwm;
    steer_dir_next    = steer_dir;
    steer_active_next = steer_active;
    idle_ticks_next   = idle_ticks;
    do_step           = 1'b0;
    act               = STEER_NONE;
    unique case (func_t'(cmd.func))
      FUNC_SPEED: begin
        target_pwm_next = 11'(cmd.speed_cmd) <<< 1;
        idle_ticks_next = '0;
        do_step         = !ramping;
      end
      FUNC_DIR: begin
        steer_dir_next    = cmd.direction_cmd;
        steer_active_next = 1'b1;
        do_step           = !ramping;
      end
      FUNC_TICK: begin
        if (fire) begin
          target_pwm_next   = '0;
          steer_dir_next    = '0;
          steer_active_next = 1'b1;
          idle_ticks_next   = '0;
        end else begin
          idle_ticks_next = idle_inc;
        end
        do_step = fire || ramping;
      end
      FUNC_POT: begin
        if (steer_active) begin
          if (err_mag < 13'(steer_deadzone)) begin
            act               = STEER_SETTLED;
            steer_active_next = 1'b0;
          end else if (err < 0) begin
            act = STEER_BACK;
          end else begin
            act = STEER_FWD;
          end
        end
      end
    endcase
  end

  // one ramp step toward the (updated) target
  assign diff     = 12'(target_pwm_next) - 12'(ramp_pwm);
  assign diff_mag = diff < 0 ? 11'(-diff) : 11'(diff);

  always_comb begin
    if (diff != 0) begin
      ramping_st = 1'b1;
      if (diff_mag < 11'(ramp_step)) begin
        ramp_st = target_pwm_next;
      end else if (diff > 0) begin
        ramp_st = ramp_pwm + 11'(ramp_step);
      end else begin
        ramp_st = ramp_pwm - 11'(ramp_step);
      end
    end else begin
      ramping_st = 1'b0;
      ramp_st    = ramp_pwm;
    end
  end

  assign ramp_pwm_next = do_step ? ramp_st : ramp_pwm;
  assign ramping_next  = do_step ? ramping_st : ramping;

  // duty base and turn factor for the scaling stages
  assign ramp_mag = ramp_st < 0 ? 10'(-ramp_st) : 10'(ramp_st);
  assign sum      = SUM_W'(ramp_mag) + SUM_W'(pwm_offset);

  always_comb begin
    base_in = '0;
    if (do_step && ramp_st != 0) begin
      if (sum > SUM_W'({PWM_BITS{1'b1}})) begin
        base_in = '1;
      end else begin
        base_in = sum[PWM_BITS-1:0];
      end
    end
  end

  assign dir_mag      = steer_dir_next < 0 ? 8'(-steer_dir_next) : 8'(steer_dir_next);
  assign fac_in       = FAC_W'(TURN_DIV) - FAC_W'(dir_mag);
  assign sel_in.left  = steer_dir_next < 0;
  assign sel_in.right = steer_dir_next > 0;

  always_comb begin
    flags_in.duty_valid   = do_step;
    flags_in.bridge_write = do_step && ramping_st;
    flags_in.steer_action = act;
    flags_in.bridge_mode  = BRIDGE_COAST;
    if (do_step && ramping_st) begin
      if (ramp_st > 0) begin
        flags_in.bridge_mode = BRIDGE_FWD;
      end else if (ramp_st < 0) begin
        flags_in.bridge_mode = BRIDGE_REV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step      <= RAMP_STEP_RST;
      pwm_offset     <= PWM_OFFSET_RST;
      steer_center   <= STEER_CENTER_RST;
      steer_deadzone <= STEER_DEADZONE_RST;
      steer_gain     <= STEER_GAIN_RST;
      stop_timeout   <= STOP_TIMEOUT_RST;
      target_pwm     <= '0;
      ramp_pwm       <= '0;
      ramping        <= 1'b0;
      steer_dir      <= '0;
      steer_active   <= 1'b0;
      idle_ticks     <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_idx_t'(cfg.index))
          CFG_RAMP_STEP:      ramp_step      <= cfg.data[7:0];
          CFG_PWM_OFFSET:     pwm_offset     <= cfg.data[9:0];
          CFG_STEER_CENTER:   steer_center   <= cfg.data[11:0];
          CFG_STEER_DEADZONE: steer_deadzone <= cfg.data[7:0];
          CFG_STEER_GAIN:     steer_gain     <= cfg.data[3:0];
          CFG_STOP_TIMEOUT:   stop_timeout   <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        target_pwm   <= target_pwm_next;
        ramp_pwm     <= ramp_pwm_next;
        ramping      <= ramping_next;
        steer_dir    <= steer_dir_next;
        steer_active <= steer_active_next;
        idle_ticks   <= idle_ticks_next;
      end
    end
  end

  // result pipeline, aligned with the scaling stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags1 <= flags_in;
      flags2 <= flags1;
      flags3 <= flags2;
    end
  end

  drsc_duty #(.PWM_BITS(PWM_BITS)) u_duty (
    .clk        (clk),
    .en         (adv),
    .base       (base_in),
    .fac        (fac_in),
    .sel        (sel_in),
    .left_duty  (res.left_duty),
    .right_duty (res.right_duty)
  );

  assign res.valid        = v3;
  assign res.duty_valid   = flags3.duty_valid;
  assign res.bridge_write = flags3.bridge_write;
  assign res.bridge_mode  = flags3.bridge_mode;
  assign res.steer_action = flags3.steer_action;

endmodule
`default_nettype wire

### rtl/core/drsc_checker.sv
// port-level checks of the drive controller and their bind
`default_nettype none
`include "drive_ramp_and_steering_controller_core_assert.svh"
module drsc_checker import drsc_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic                duty_valid,
  input logic [PWM_BITS-1:0] left_duty,
  input logic [PWM_BITS-1:0] right_duty,
  input logic                bridge_write,
  input logic [1:0]          bridge_mode,
  input logic [1:0]          steer_action
);

  // a stalled word holds
  `DRSC_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(left_duty) && $stable(right_duty) && $stable(bridge_mode) && $stable(steer_action))

  // no ramp step means quiet motor outputs
  `DRSC_ASSERT_IMPL(a_no_step_quiet, res_valid && !duty_valid, left_duty == '0 && right_duty == '0 && !bridge_write && bridge_mode == BRIDGE_COAST)

  // steering words never carry a ramp step
  `DRSC_ASSERT_IMPL(a_steer_no_step, res_valid && steer_action != STEER_NONE, !duty_valid)

  // a driven bridge has at least the outer wheel running
  `DRSC_ASSERT_IMPL(a_drive_nonzero, res_valid && bridge_write && bridge_mode != BRIDGE_COAST, left_duty != '0 || right_duty != '0)

  `DRSC_ASSERT_RESET(a_reset_empty, !res_valid)

endmodule

bind drive_ramp_and_steering_controller_core drsc_checker #(.PWM_BITS(PWM_BITS)) u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .duty_valid   (res.duty_valid),
  .left_duty    (res.left_duty),
  .right_duty   (res.right_duty),
  .bridge_write (res.bridge_write),
  .bridge_mode  (res.bridge_mode),
  .steer_action (res.steer_action)
);
`default_nettype wire
